// ===== rtl/core/keypad_scan_pin_lock_unit_defines.svh =====
// assertion macros for the keypad scanner with pin lock
// used by the top level and the pin entry module, no other dependencies
`ifndef KEYPAD_SCAN_PIN_LOCK_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_PIN_LOCK_UNIT_DEFINES_SVH

// same-cycle implication
`define KSPL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSPL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kspl_pkg.sv =====
// types, constants and key decode for the keypad scanner with pin lock
// no dependencies
`default_nettype none

package kspl_pkg;

  localparam int unsigned PIN_W      = 27;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned DEB_W      = 20;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [LEN_W-1:0] MAX_PIN_DIGITS = 4'd8;

  localparam logic [PIN_W-1:0] PIN_CODE_RST       = 27'd1234;
  localparam logic [LEN_W-1:0] PIN_LENGTH_RST     = 4'd4;
  localparam logic [DEB_W-1:0] DEBOUNCE_TICKS_RST = 20'd100000;

  localparam logic [1:0] REG_PIN_CODE       = 2'd0;
  localparam logic [1:0] REG_PIN_LENGTH     = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd2;

  localparam logic [3:0] KEY_ENTER = 4'd10;
  localparam logic [3:0] KEY_CLEAR = 4'd11;
  localparam logic [3:0] KEY_NONE  = 4'd15;

  typedef enum logic [1:0] {
    PH_SCAN     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_HOLD     = 2'd2
  } kspl_phase_t;

  typedef struct packed {
    logic       fire;
    logic [3:0] code;
  } kspl_key_t;

  typedef struct packed {
    logic checked;
    logic match;
  } kspl_check_t;

  function automatic logic [1:0] lowest_col(input logic [3:0] cols);
    logic [1:0] c;
    if (cols[0]) begin
      c = 2'd0;
    end else if (cols[1]) begin
      c = 2'd1;
    end else if (cols[2]) begin
      c = 2'd2;
    end else begin
      c = 2'd3;
    end
    return c;
  endfunction

  function automatic logic [3:0] decode_key(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] k;
    unique case ({row, col})
      4'b00_01: k = KEY_ENTER;
      4'b00_10: k = 4'd0;
      4'b00_11: k = KEY_CLEAR;
      4'b01_01: k = 4'd9;
      4'b01_10: k = 4'd8;
      4'b01_11: k = 4'd7;
      4'b10_01: k = 4'd6;
      4'b10_10: k = 4'd5;
      4'b10_11: k = 4'd4;
      4'b11_01: k = 4'd3;
      4'b11_10: k = 4'd2;
      4'b11_11: k = 4'd1;
      default:  k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kspl_pin_entry.sv =====
// decimal pin entry: digit accumulation, clear and compare on enter
// depends on kspl_pkg and keypad_scan_pin_lock_unit_defines.svh
`default_nettype none
`include "keypad_scan_pin_lock_unit_defines.svh"

module kspl_pin_entry
  import kspl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kspl_key_t        key,
  input  wire logic [PIN_W-1:0] pin_code,
  input  wire logic [LEN_W-1:0] pin_length,
  output kspl_check_t           check
);

  logic [LEN_W-1:0] digit_count;
  logic [LEN_W-1:0] digit_count_next;
  logic [PIN_W-1:0] entered_value;
  logic [PIN_W-1:0] entered_value_next;
  logic [LEN_W-1:0] limit;
  logic [PIN_W-1:0] times_ten;

  assign limit     = (pin_length > MAX_PIN_DIGITS) ? MAX_PIN_DIGITS : pin_length;
  assign times_ten = {entered_value[PIN_W-4:0], 3'b000} + {entered_value[PIN_W-2:0], 1'b0};

  always_comb begin
    digit_count_next   = digit_count;
    entered_value_next = entered_value;
    check              = '0;
    if (key.fire) begin
      case (key.code)
        KEY_ENTER: begin
          check.checked      = 1'b1;
          check.match        = (entered_value == pin_code);
          digit_count_next   = '0;
          entered_value_next = '0;
        end
        KEY_CLEAR: begin
          digit_count_next   = '0;
          entered_value_next = '0;
        end
        default: begin
          if (digit_count < limit) begin
            digit_count_next   = digit_count + 4'd1;
            entered_value_next = times_ten + {{(PIN_W-4){1'b0}}, key.code};
          end else begin
            digit_count_next   = '0;
            entered_value_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count   <= '0;
      entered_value <= '0;
    end else begin
      digit_count   <= digit_count_next;
      entered_value <= entered_value_next;
    end
  end

  `KSPL_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, digit_count <= MAX_PIN_DIGITS, "digit count above limit")
  `KSPL_ASSERT_NXT(a_enter_clears, clk, rst, key.fire && key.code == KEY_ENTER, digit_count == '0 && entered_value == '0, "entry not cleared after enter")
  `KSPL_ASSERT_NXT(a_idle_holds, clk, rst, !key.fire, $stable(digit_count) && $stable(entered_value), "entry changed without a key")

endmodule

`default_nettype wire

// ===== rtl/core/keypad_scan_pin_lock_unit.sv =====
// keypad scanner with pin lock: usage
// each transfer on the input channel is one scan tick carrying column_levels,
// sampled while the row_drive of the previous result was applied (row 0 after
// reset). each tick yields exactly one result on the output channel: the row
// to drive next, a key release event with its code, and the pin check result.
// the result is registered, valid in the cycle after the input transfer; one
// tick is accepted every cycle, set by the single result register. when the
// receiver stalls, the result register holds and in_stall is raised only
// while a held result waits, so throughput drops to the receiver's rate.
// reset clears the scan to row 0, scanning phase, the pin entry to empty and
// loads pin_code 1234, pin_length 4, debounce_ticks 100000.
// registers through the apb port: pin_code at 0x0, pin_length at 0x4,
// debounce_ticks at 0x8; write only while no tick is in flight.
// depends on kspl_pkg, kspl_pin_entry and keypad_scan_pin_lock_unit_defines.svh
`default_nettype none
`include "keypad_scan_pin_lock_unit_defines.svh"

module keypad_scan_pin_lock_unit
  import kspl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [3:0]            column_levels,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 row_drive,
  output logic                       key_event,
  output logic [3:0]                 key_code,
  output logic                       pin_checked,
  output logic                       pin_match
);

  logic [PIN_W-1:0] pin_code;
  logic [LEN_W-1:0] pin_length;
  logic [DEB_W-1:0] debounce_ticks;
  logic             cfg_write;

  kspl_phase_t      phase;
  kspl_phase_t      phase_next;
  logic [1:0]       scan_row;
  logic [1:0]       scan_row_next;
  logic [DEB_W-1:0] debounce_count;
  logic [DEB_W-1:0] debounce_count_next;
  logic [DEB_W-1:0] count_dec;
  logic [1:0]       held_column;
  logic [1:0]       held_column_next;
  logic [3:0]       held_key;
  logic [3:0]       held_key_next;
  logic             released;
  logic             in_fire;
  kspl_key_t        key;
  kspl_check_t      check;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_code       <= PIN_CODE_RST;
      pin_length     <= PIN_LENGTH_RST;
      debounce_ticks <= DEBOUNCE_TICKS_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_PIN_CODE:       pin_code       <= pwdata[PIN_W-1:0];
        REG_PIN_LENGTH:     pin_length     <= pwdata[LEN_W-1:0];
        REG_DEBOUNCE_TICKS: debounce_ticks <= pwdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PIN_CODE:       prdata = {{(APB_DATA_W-PIN_W){1'b0}}, pin_code};
      REG_PIN_LENGTH:     prdata = {{(APB_DATA_W-LEN_W){1'b0}}, pin_length};
      REG_DEBOUNCE_TICKS: prdata = {{(APB_DATA_W-DEB_W){1'b0}}, debounce_ticks};
      default:            prdata = '0;
    endcase
  end

  // handshake
  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  assign released  = !column_levels[held_column];
  assign count_dec = (debounce_count != '0) ? debounce_count - 20'd1 : '0;

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_DEBOUNCE: begin
        if (count_dec == '0) phase_next = PH_HOLD;
      end
      PH_HOLD: begin
        if (released) phase_next = PH_SCAN;
      end
      default: begin
        if (column_levels != 4'd0) begin
          phase_next = (debounce_ticks == '0) ? PH_HOLD : PH_DEBOUNCE;
        end else begin
          phase_next = PH_SCAN;
        end
      end
    endcase
  end

  // per-phase datapath
  always_comb begin
    scan_row_next       = scan_row;
    debounce_count_next = debounce_count;
    held_column_next    = held_column;
    held_key_next       = held_key;
    key                 = '0;
    unique case (phase)
      PH_DEBOUNCE: begin
        debounce_count_next = count_dec;
      end
      PH_HOLD: begin
        if (released) begin
          key.fire      = in_fire && (held_key <= KEY_CLEAR);
          key.code      = (held_key <= KEY_CLEAR) ? held_key : 4'd0;
          held_key_next = KEY_NONE;
          scan_row_next = 2'd0;
        end
      end
      default: begin
        if (column_levels != 4'd0) begin
          held_column_next    = lowest_col(column_levels);
          held_key_next       = decode_key(scan_row, lowest_col(column_levels));
          debounce_count_next = debounce_ticks;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      scan_row       <= 2'd0;
      debounce_count <= '0;
      held_column    <= 2'd0;
      held_key       <= KEY_NONE;
    end else if (in_fire) begin
      phase          <= phase_next;
      scan_row       <= scan_row_next;
      debounce_count <= debounce_count_next;
      held_column    <= held_column_next;
      held_key       <= held_key_next;
    end
  end

  kspl_pin_entry u_entry (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .pin_code   (pin_code),
    .pin_length (pin_length),
    .check      (check)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_drive   <= 4'd1 << scan_row_next;
      key_event   <= key.fire;
      key_code    <= key.code;
      pin_checked <= check.checked;
      pin_match   <= check.match;
    end
  end

  `KSPL_ASSERT_IMP(a_debounce_nonzero, clk, rst, phase == PH_DEBOUNCE, debounce_count != '0, "debounce phase with zero count")
  `KSPL_ASSERT_IMP(a_event_code, clk, rst, out_valid && key_event, key_code <= KEY_CLEAR, "key event with unmapped code")
  `KSPL_ASSERT_NXT(a_release_rescan, clk, rst, in_fire && phase == PH_HOLD && released, phase == PH_SCAN && scan_row == 2'd0, "scan not restarted after release")

endmodule

`default_nettype wire

// ===== sim/tb_keypad_scan_pin_lock_unit.sv =====
// self-checking testbench for keypad_scan_pin_lock_unit: drives scan ticks of
// column levels, predicts every result from its own keypad and pin entry model
// and compares it field by field; depends on kspl_pkg and the unit's rtl
`default_nettype none

module tb_keypad_scan_pin_lock_unit
  import kspl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_TICKS = 140;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef logic [PIN_W-1:0] pin_value_t;

  typedef struct packed {
    kspl_phase_t      phase;
    logic [1:0]       row;
    logic [DEB_W-1:0] count;
    logic [1:0]       col;
    logic [3:0]       key;
    logic [3:0]       digits;
    pin_value_t       value;
  } keypad_state_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_event;
    logic [3:0] key_code;
    logic       pin_checked;
    logic       pin_match;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic [3:0] column_levels;
  logic out_valid;
  logic out_stall;
  logic [3:0] row_drive;
  logic key_event;
  logic [3:0] key_code;
  logic pin_checked;
  logic pin_match;

  pin_value_t       cfg_pin_code;
  logic [LEN_W-1:0] cfg_pin_length;
  logic [DEB_W-1:0] cfg_debounce;

  keypad_state_t lock_model;
  keypad_state_t plan_model;
  tick_result_t  predicted;
  tick_result_t  want;
  tick_result_t  expected_ticks[$];
  logic [3:0]    pending_levels[$];
  int            pin_digits[$];
  int            idle_mode;
  int            item_count;
  int            mismatch_count;
  int            cycle_count;

  keypad_scan_pin_lock_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .column_levels (column_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_drive     (row_drive),
    .key_event     (key_event),
    .key_code      (key_code),
    .pin_checked   (pin_checked),
    .pin_match     (pin_match)
  );

  always #1ns clk = ~clk;

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch: %s", what);
    end
  endtask

  // one scan tick of the keypad and pin entry
  task automatic scan_tick(inout keypad_state_t s, input logic [3:0] cols,
                           output tick_result_t r);
    logic [1:0]       c;
    logic [LEN_W-1:0] lim;
    r = '0;
    c = 2'd0;
    case (s.phase)
      PH_DEBOUNCE: begin
        if (s.count != '0) s.count = s.count - 1'b1;
        if (s.count == '0) s.phase = PH_HOLD;
      end
      PH_HOLD: begin
        if (!cols[s.col]) begin
          if (s.key <= KEY_CLEAR) begin
            r.key_event = 1'b1;
            r.key_code = s.key;
            if (s.key == KEY_ENTER) begin
              r.pin_checked = 1'b1;
              r.pin_match = (s.value == cfg_pin_code);
              s.digits = '0;
              s.value = '0;
            end else if (s.key == KEY_CLEAR) begin
              s.digits = '0;
              s.value = '0;
            end else begin
              if (cfg_pin_length > MAX_PIN_DIGITS) lim = MAX_PIN_DIGITS;
              else lim = cfg_pin_length;
              if (s.digits < lim) begin
                s.digits = s.digits + 1'b1;
                s.value = pin_value_t'(s.value * 10 + s.key);
              end else begin
                s.digits = '0;
                s.value = '0;
              end
            end
          end
          s.key = KEY_NONE;
          s.phase = PH_SCAN;
          s.row = 2'd0;
        end
      end
      default: begin
        s.phase = PH_SCAN;
        if (cols != 4'd0) begin
          for (int i = 3; i >= 0; i--) begin
            if (cols[i]) c = 2'(i);
          end
          s.col = c;
          if (s.row == 2'd0) begin
            case (c)
              2'd1: s.key = KEY_ENTER;
              2'd2: s.key = 4'd0;
              2'd3: s.key = KEY_CLEAR;
              default: s.key = KEY_NONE;
            endcase
          end else if (c == 2'd0) begin
            s.key = KEY_NONE;
          end else begin
            s.key = 4'((3 - s.row) * 3 + (4 - c));
          end
          s.count = cfg_debounce;
          if (cfg_debounce == '0) s.phase = PH_HOLD;
          else s.phase = PH_DEBOUNCE;
        end else begin
          s.row = s.row + 2'd1;
        end
      end
    endcase
    r.row_drive = 4'b0001 << s.row;
  endtask

  function automatic bit take_break(input bit sender);
    int pct;
    case (idle_mode)
      IDLE_SEND: pct = sender ? 84 : 0;
      IDLE_RECV: pct = sender ? 0 : 84;
      IDLE_BOTH: pct = 12;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_tick(lock_model, column_levels, predicted);
        expected_ticks.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (pending_levels.size() != 0 && !take_break(1'b1)) begin
          in_valid <= 1'b1;
          column_levels <= pending_levels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          note_failure("result transfer with no tick pending");
        end else begin
          want = expected_ticks.pop_front();
          if (row_drive !== want.row_drive || key_event !== want.key_event ||
              key_code !== want.key_code || pin_checked !== want.pin_checked ||
              pin_match !== want.pin_match) begin
            note_failure($sformatf(
              "exp row %h ev %b code %0d chk %b match %b, got row %h ev %b code %0d chk %b match %b",
              want.row_drive, want.key_event, want.key_code, want.pin_checked,
              want.pin_match, row_drive, key_event, key_code, pin_checked, pin_match));
          end
        end
      end
      out_stall <= take_break(1'b0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic apb_access(input bit wr, input logic [1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] expect_val);
    logic [31:0] got;
    apb_access(1'b0, idx, 32'd0, got);
    if (got !== expect_val) begin
      note_failure($sformatf("register %0d read exp %h got %h", idx, expect_val, got));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] unused_rd;
    logic [31:0] readback;
    apb_access(1'b1, idx, value, unused_rd);
    case (idx)
      REG_PIN_CODE: begin
        cfg_pin_code = value[PIN_W-1:0];
        readback = 32'(cfg_pin_code);
      end
      REG_PIN_LENGTH: begin
        cfg_pin_length = value[LEN_W-1:0];
        readback = 32'(cfg_pin_length);
      end
      default: begin
        cfg_debounce = value[DEB_W-1:0];
        readback = 32'(cfg_debounce);
      end
    endcase
    check_reg(idx, readback);
  endtask

  task automatic set_pin(input int n, input bit nines);
    pin_value_t v;
    int d;
    pin_digits.delete();
    v = '0;
    repeat (n) begin
      d = nines ? 9 : int'($urandom_range(0, 9));
      pin_digits.push_back(d);
      v = pin_value_t'(v * 10 + d);
    end
    write_reg(REG_PIN_CODE, 32'(v));
  endtask

  task automatic queue_tick(input logic [3:0] cols);
    tick_result_t scratch;
    scan_tick(plan_model, cols, scratch);
    pending_levels.push_back(cols);
    item_count++;
  endtask

  // brings the planned scan back to scanning, then presses and releases a key
  task automatic press_key(input logic [3:0] key);
    int r;
    int c;
    while (plan_model.phase != PH_SCAN) queue_tick(4'($urandom_range(0, 15)));
    if (key == 4'd0) begin
      r = 0;
      c = 2;
    end else if (key == KEY_ENTER) begin
      r = 0;
      c = 1;
    end else if (key == KEY_CLEAR) begin
      r = 0;
      c = 3;
    end else if (key > KEY_CLEAR) begin
      r = $urandom_range(0, 3);
      c = 0;
    end else begin
      r = 3 - (key - 1) / 3;
      c = 3 - (key - 1) % 3;
    end
    while (plan_model.row != 2'(r)) queue_tick(4'd0);
    queue_tick(4'(1 << c) | 4'($urandom_range(0, 15) << (c + 1)));
    while (plan_model.phase == PH_DEBOUNCE) queue_tick(4'($urandom_range(0, 15)));
    repeat ($urandom_range(0, 2)) queue_tick(4'($urandom_range(0, 15)) | 4'(1 << c));
    queue_tick(4'($urandom_range(0, 15)) & ~4'(1 << c));
  endtask

  task automatic try_pin();
    int n;
    int choice;
    int d;
    choice = $urandom_range(0, 9);
    n = pin_digits.size();
    if ($urandom_range(0, 3) != 0) press_key(KEY_CLEAR);
    for (int i = 0; i < n; i++) begin
      d = pin_digits[i];
      if (choice == 0 && i == n - 1) d = (d + 1) % 10;
      press_key(4'(d));
      if (choice == 1 && i == n / 2) press_key(KEY_CLEAR);
    end
    if (choice == 2) press_key(4'($urandom_range(0, 9)));
    if (choice != 3) press_key(KEY_ENTER);
  endtask

  task automatic wait_drained();
    while (pending_levels.size() != 0 || in_valid || expected_ticks.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int start;
    int sel;
    int n;
    rst = 1'b1;
    in_valid = 1'b0;
    column_levels = 4'd0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_mode = IDLE_NONE;
    item_count = 0;
    mismatch_count = 0;
    cycle_count = 0;
    cfg_pin_code = PIN_CODE_RST;
    cfg_pin_length = PIN_LENGTH_RST;
    cfg_debounce = DEBOUNCE_TICKS_RST;
    plan_model.phase = PH_SCAN;
    plan_model.row = 2'd0;
    plan_model.count = '0;
    plan_model.col = 2'd0;
    plan_model.key = KEY_NONE;
    plan_model.digits = '0;
    plan_model.value = '0;
    lock_model = plan_model;
    pin_digits = '{1, 2, 3, 4};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    check_reg(REG_PIN_CODE, 32'(PIN_CODE_RST));
    check_reg(REG_PIN_LENGTH, 32'(PIN_LENGTH_RST));
    check_reg(REG_DEBOUNCE_TICKS, 32'(DEBOUNCE_TICKS_RST));
    write_reg(REG_DEBOUNCE_TICKS, 32'hF_FFFF);
    write_reg(REG_DEBOUNCE_TICKS, 32'd0);

    // unmapped col 0 press, all cols high, then clear, 0, enter, 9, unmapped
    queue_tick(4'h0);
    queue_tick(4'hF);
    queue_tick(4'hF);
    queue_tick(4'hE);
    press_key(KEY_CLEAR);
    press_key(4'd0);
    press_key(KEY_ENTER);
    press_key(4'd9);
    press_key(KEY_NONE);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          idle_mode = IDLE_NONE;
          write_reg(REG_DEBOUNCE_TICKS, 32'd0);
        end
        1: begin
          idle_mode = IDLE_SEND;
          set_pin(8, 1'b1);
          write_reg(REG_PIN_LENGTH, 32'd8);
          write_reg(REG_DEBOUNCE_TICKS, 32'd1);
        end
        2: begin
          idle_mode = IDLE_RECV;
          set_pin(1, 1'b0);
          write_reg(REG_PIN_LENGTH, 32'd1);
          write_reg(REG_DEBOUNCE_TICKS, 32'd2);
        end
        3: begin
          idle_mode = IDLE_BOTH;
          set_pin(0, 1'b0);
          write_reg(REG_PIN_LENGTH, 32'd0);
          write_reg(REG_DEBOUNCE_TICKS, 32'd0);
        end
        4: begin
          idle_mode = IDLE_NONE;
          set_pin(8, 1'b0);
          write_reg(REG_PIN_LENGTH, 32'd15);
          write_reg(REG_DEBOUNCE_TICKS, 32'd3);
        end
        5: idle_mode = IDLE_SEND;
        6: idle_mode = IDLE_RECV;
        default: idle_mode = IDLE_BOTH;
      endcase
      if (ph >= 5) begin
        n = $urandom_range(1, 8);
        set_pin(n, 1'b0);
        write_reg(REG_PIN_LENGTH, 32'(n));
        write_reg(REG_DEBOUNCE_TICKS, 32'($urandom_range(0, 4)));
      end
      start = item_count;
      while (item_count - start < PHASE_TICKS) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
          try_pin();
        end else if (sel < 8) begin
          press_key(4'($urandom_range(0, 11)));
        end else if (sel == 8) begin
          press_key(KEY_NONE);
        end else begin
          repeat ($urandom_range(1, 6)) queue_tick(4'($urandom_range(0, 15)));
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kspl_pkg.sv
rtl/core/kspl_pin_entry.sv
rtl/core/keypad_scan_pin_lock_unit.sv
sim/tb_keypad_scan_pin_lock_unit.sv
